>>> hdl/life_torus_generation_step_top_defines.svh
// ============================================================================
// Life board assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ============================================================================
`ifndef LIFE_TORUS_GENERATION_STEP_TOP_DEFINES_SVH
`define LIFE_TORUS_GENERATION_STEP_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lts_pkg.sv
// ============================================================================
// Life board package
// Types, codes and defaults shared by the toroidal life board modules.
// ============================================================================
package lts_pkg;

    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 64;

    localparam int IDX_W = 6;   // width of the row and column index fields
    localparam int CNT_W = 4;   // width of a neighbor count and of the birth count

    localparam logic [CNT_W-1:0] BIRTH_RESET = 4'd3;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_STEP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_STEP
    } t_state;

endpackage

>>> hdl/life_torus_generation_step_top.sv
// ============================================================================
// Toroidal life board
// Command-driven board of ROWS x COLS cells with wrapped edges: write, read,
// clear, and advance one generation under a configurable birth count.
// ============================================================================
// Read and write: the row read is registered in the RAM, then the result strobe.
// Clear: result strobe in the cycle after the accepting edge.
// Step: the sweep reads one board row and writes one per cycle through the row
//   RAM, and the result strobe is registered at its end.
// A new item may be started in the cycle its predecessor's result is shown.
// Reset clears the per-row valid flags, so the board reads all dead at once.
module life_torus_generation_step_top #(
    parameter int ROWS = lts_pkg::DEF_ROWS,
    parameter int COLS = lts_pkg::DEF_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_command,
    input  logic [lts_pkg::IDX_W-1:0] i_row_index,
    input  logic [lts_pkg::IDX_W-1:0] i_col_index,
    input  logic                     i_cell_value,
    output logic                     o_done,
    output logic                     o_read_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [lts_pkg::CNT_W-1:0] i_cfg_birth_count
);

    import lts_pkg::*;

    localparam int RW = $clog2(ROWS);

    logic [CNT_W-1:0] r_birth_count;
    logic             ram_we;
    logic [RW-1:0]    ram_waddr;
    logic [COLS-1:0]  ram_wdata;
    logic [RW-1:0]    ram_raddr;
    logic [COLS-1:0]  ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth_count <= BIRTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_birth_count <= i_cfg_birth_count;
        end
    end

    lts_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_command     (i_command),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_cell_value  (i_cell_value),
        .i_birth_count (r_birth_count),
        .o_done        (o_done),
        .o_read_value  (o_read_value),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

    lts_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_board (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

>>> hdl/lts_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module lts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lts_rule.sv
// ============================================================================
// Life row update
// Builds one new board row from the old rows above, at and below it.
// ============================================================================
module lts_rule #(
    parameter int COLS = lts_pkg::DEF_COLS
) (
    input  logic [COLS-1:0]          i_up,
    input  logic [COLS-1:0]          i_mid,
    input  logic [COLS-1:0]          i_dn,
    input  logic [lts_pkg::CNT_W-1:0] i_birth_count,
    output logic [COLS-1:0]          o_row
);

    import lts_pkg::*;

    for (genvar c = 0; c < COLS; c++) begin : g_col
        // Columns wrap around at both edges.
        localparam int L = (c == 0) ? COLS - 1 : c - 1;
        localparam int R = (c == COLS - 1) ? 0 : c + 1;

        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] n_plus;

        assign n = CNT_W'(i_up[L]) + CNT_W'(i_up[c]) + CNT_W'(i_up[R])
                 + CNT_W'(i_mid[L]) + CNT_W'(i_mid[R])
                 + CNT_W'(i_dn[L]) + CNT_W'(i_dn[c]) + CNT_W'(i_dn[R]);
        assign n_plus = n + CNT_W'(1);

        assign o_row[c] = i_mid[c] ? ((n == i_birth_count) || (n_plus == i_birth_count))
                                   : (n == i_birth_count);
    end

endmodule

>>> hdl/lts_ctrl.sv
// ============================================================================
// Life board controller
// Command sequencer: cell read-modify-write, row valid flags and the
// row-by-row generation sweep with its three-row window.
// ============================================================================
`include "life_torus_generation_step_top_defines.svh"

module lts_ctrl #(
    parameter int ROWS = lts_pkg::DEF_ROWS,
    parameter int COLS = lts_pkg::DEF_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [1:0]               i_command,
    input  logic [lts_pkg::IDX_W-1:0] i_row_index,
    input  logic [lts_pkg::IDX_W-1:0] i_col_index,
    input  logic                     i_cell_value,
    input  logic [lts_pkg::CNT_W-1:0] i_birth_count,
    output logic                     o_done,
    output logic                     o_read_value,
    output logic                     o_ram_we,
    output logic [$clog2(ROWS)-1:0]  o_ram_waddr,
    output logic [COLS-1:0]          o_ram_wdata,
    output logic [$clog2(ROWS)-1:0]  o_ram_raddr,
    input  logic [COLS-1:0]          i_ram_rdata
);

    import lts_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int KW = $clog2(ROWS + 2);
    localparam int XW = (RW > IDX_W) ? RW : IDX_W;

    t_state r_state, n_state;
    logic [KW-1:0]   r_cnt, n_cnt;
    logic [ROWS-1:0] r_row_vld;
    logic            r_rd_vld;
    logic [RW-1:0]   r_cmd_row;
    logic [CW-1:0]   r_cmd_col;
    logic            r_cmd_val;
    logic            r_on_board;
    logic            r_done;
    logic            r_read_value;
    logic [COLS-1:0] r_row_a;
    logic [COLS-1:0] r_row_b;
    logic [COLS-1:0] r_row0;

    logic [XW-1:0]   row_x;
    logic [RW-1:0]   in_row;
    logic            in_on_board;
    logic            accept;
    logic            rd_en;
    logic [RW-1:0]   rd_addr;
    logic            ram_we;
    logic [RW-1:0]   waddr;
    logic [COLS-1:0] wdata;
    logic [COLS-1:0] rd_row;
    logic [COLS-1:0] incoming;
    logic [COLS-1:0] new_row;
    logic [KW-1:0]   cnt_m2;
    logic            set_done;

    assign row_x       = XW'(i_row_index);
    assign in_row      = row_x[RW-1:0];
    assign in_on_board = (32'(i_row_index) < 32'(ROWS)) && (32'(i_col_index) < 32'(COLS));
    assign accept      = i_start && (r_state == S_IDLE);

    // A row never written since reset or the last clear reads as all dead.
    assign rd_row   = r_rd_vld ? i_ram_rdata : '0;
    assign incoming = (r_cnt == KW'(ROWS + 1)) ? r_row0 : rd_row;
    assign cnt_m2   = r_cnt - KW'(2);

    lts_rule #(
        .COLS (COLS)
    ) u_rule (
        .i_up          (r_row_a),
        .i_mid         (r_row_b),
        .i_dn          (incoming),
        .i_birth_count (i_birth_count),
        .o_row         (new_row)
    );

    always_comb begin
        logic [COLS-1:0] cell_row;
        n_state  = r_state;
        n_cnt    = r_cnt;
        rd_en    = 1'b0;
        rd_addr  = '0;
        ram_we   = 1'b0;
        waddr    = r_cmd_row;
        wdata    = new_row;
        set_done = 1'b0;
        cell_row = rd_row;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            rd_en   = 1'b1;
                            rd_addr = in_row;
                            n_state = S_WRITE;
                        end
                        CMD_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = in_row;
                            n_state = S_READ;
                        end
                        CMD_CLEAR: begin
                            set_done = 1'b1;
                        end
                        CMD_STEP: begin
                            // The sweep starts from the last row, the upper wrap neighbor.
                            rd_en   = 1'b1;
                            rd_addr = RW'(ROWS - 1);
                            n_cnt   = '0;
                            n_state = S_STEP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                set_done = 1'b1;
                n_state  = S_IDLE;
            end
            S_WRITE: begin
                cell_row[r_cmd_col] = r_cmd_val;
                ram_we   = r_on_board;
                waddr    = r_cmd_row;
                wdata    = cell_row;
                set_done = 1'b1;
                n_state  = S_IDLE;
            end
            S_STEP: begin
                // At count k the RAM returns old row k-1 and new row k-2 is written.
                if (r_cnt < KW'(ROWS)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt[RW-1:0];
                end
                if (r_cnt >= KW'(2)) begin
                    ram_we = 1'b1;
                    waddr  = cnt_m2[RW-1:0];
                    wdata  = new_row;
                end
                if (r_cnt == KW'(ROWS + 1)) begin
                    set_done = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt = r_cnt + KW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_row_vld <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= set_done;
            if (accept && (t_cmd'(i_command) == CMD_CLEAR)) begin
                r_row_vld <= '0;
            end else if (ram_we) begin
                r_row_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= rd_en ? r_row_vld[rd_addr] : 1'b0;
        if (accept) begin
            r_cmd_row  <= in_row;
            r_cmd_col  <= i_col_index[CW-1:0];
            r_cmd_val  <= i_cell_value;
            r_on_board <= in_on_board;
        end
        if (set_done) begin
            r_read_value <= (r_state == S_READ) && r_on_board && rd_row[r_cmd_col];
        end
        if (r_state == S_STEP) begin
            r_row_a <= r_row_b;
            r_row_b <= incoming;
            if (r_cnt == KW'(1)) begin
                r_row0 <= incoming;
            end
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = r_read_value;
    assign o_ram_we     = ram_we;
    assign o_ram_waddr  = waddr;
    assign o_ram_wdata  = wdata;
    assign o_ram_raddr  = rd_addr;

    `LTS_ASSERT_IMP(a_done_when_free, r_done, !o_busy, "result strobe while busy")
    `LTS_ASSERT_IMP(a_we_state, ram_we, (r_state == S_WRITE) || (r_state == S_STEP),
        "board write outside a write or step")
    `LTS_ASSERT_IMP(a_no_rw_clash, ram_we && rd_en, waddr != rd_addr,
        "row read and written in the same cycle")
    `LTS_ASSERT_NEXT(a_step_start, accept && (t_cmd'(i_command) == CMD_STEP),
        (r_state == S_STEP) && (r_cnt == '0), "step did not start its sweep")

endmodule
